### src/mfr_pkg.sv
`default_nettype none
package mfr_pkg;

  localparam int FIX_ONE  = 65536;
  localparam int DIV_BITS = 16;
  localparam int MAG_BITS = 32;
  localparam int LANES    = 4;

  localparam logic signed [17:0] KAPPA_RESET   = 18'sd21845;
  localparam logic        [16:0] EPSILON_RESET = 17'd65536;

  typedef enum logic {
    REG_KAPPA   = 1'b0,
    REG_EPSILON = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                 op;
    logic signed [31:0]   ql;
    logic signed [31:0]   qr;
    logic signed [32:0]   d1;
    logic signed [32:0]   d2;
    logic signed [32:0]   d3;
    logic [LANES-1:0]     fix;
    logic [LANES-1:0]     fone;
  } carry_t;

  typedef struct packed {
    logic                 fix;
    logic                 fone;
    logic [MAG_BITS-1:0]  an;
    logic [MAG_BITS-1:0]  ad;
  } lset_t;

endpackage
`default_nettype wire

### src/mfr_if.sv
`default_nettype none
interface mfr_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] q_far_left;
  logic signed [31:0] q_left;
  logic signed [31:0] q_right;
  logic signed [31:0] q_far_right;
  modport source (output valid, opcode, q_far_left, q_left, q_right, q_far_right,
                  input ready);
  modport sink   (input valid, opcode, q_far_left, q_left, q_right, q_far_right,
                  output ready);
endinterface

interface mfr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_state;
  logic signed [31:0] right_state;
  modport source (output valid, left_state, right_state, input ready);
  modport sink   (input valid, left_state, right_state, output ready);
endinterface
`default_nettype wire

### src/mfr_div_pipe.sv
`default_nettype none
module mfr_div_pipe #(
  parameter int STEPS = 16,
  parameter int W     = 32
) (
  input  wire logic             clk,
  input  wire logic [STEPS-1:0] en,
  input  wire logic [W-1:0]     rem_i,
  input  wire logic [W-1:0]     ad_i,
  output logic      [STEPS-1:0] q_o
);

  logic [W-1:0]     rem_r [STEPS];
  logic [W-1:0]     ad_r  [STEPS];
  logic [STEPS-1:0] q_r   [STEPS];
  logic [W-1:0]     rem_src [STEPS];
  logic [W-1:0]     ad_src  [STEPS];
  logic [STEPS-1:0] q_src   [STEPS];
  logic [W-1:0]     rem_nxt [STEPS];
  logic [STEPS-1:0] q_nxt   [STEPS];

  always_comb begin
    logic [W:0] r2;
    logic [W:0] diff;
    logic       ge;
    for (int j = 0; j < STEPS; j++) begin
      if (j == 0) begin
        rem_src[j] = rem_i;
        ad_src[j]  = ad_i;
        q_src[j]   = '0;
      end else begin
        rem_src[j] = rem_r[j-1];
        ad_src[j]  = ad_r[j-1];
        q_src[j]   = q_r[j-1];
      end
      r2   = {rem_src[j], 1'b0};
      diff = r2 - {1'b0, ad_src[j]};
      ge   = r2 >= {1'b0, ad_src[j]};
      rem_nxt[j] = ge ? diff[W-1:0] : r2[W-1:0];
      q_nxt[j]   = {q_src[j][STEPS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < STEPS; j++) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt[j];
        ad_r[j]  <= ad_src[j];
        q_r[j]   <= q_nxt[j];
      end
    end
  end

  assign q_o = q_r[STEPS-1];

endmodule
`default_nettype wire

### src/muscl_face_reconstruction.sv
`default_nettype none
// channel   dir  handshake      payload
// in_ch     in   valid/ready    opcode, q_far_left, q_left, q_right, q_far_right
// out_ch    out  valid/ready    left_state, right_state
// cfg_*     in   APB write/read kappa (addr 0), epsilon (addr 4)
//
// One request per cycle unless out_ch stalls; each passes through every stage register to out_ch.valid.
// Most of the depth comes from the four 16-step restoring dividers, one quotient bit a stage.
// Every stage holds its own valid bit and advances when empty or when the next moves.
// Synchronous active-low reset clears valid bits and sets kappa and epsilon to defaults.
module muscl_face_reconstruction #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mfr_in_if.sink           in_ch,
  mfr_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import mfr_pkg::*;

  localparam int EFF_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int S_SET  = 1;
  localparam int S_DIV0 = 2;
  localparam int S_TA   = S_DIV0 + DIV_BITS;
  localparam int S_PW   = S_TA + 1;
  localparam int S_SUM  = S_PW + 1;
  localparam int S_EPS  = S_SUM + 1;
  localparam int S_OUT  = S_EPS + 1;
  localparam int NST    = S_OUT + 1;
  localparam logic signed [38:0] SAT_HI = (39'sd1 <<< (EFF_BITS - 1)) - 39'sd1;
  localparam logic signed [38:0] SAT_LO = -SAT_HI - 39'sd1;

  function automatic logic signed [31:0] sx(input logic [31:0] x);
    logic signed [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = (i < EFF_BITS) ? x[i] : x[EFF_BITS-1];
    return r;
  endfunction

  function automatic lset_t lim_setup(input logic signed [32:0] n,
                                      input logic signed [32:0] m);
    lset_t      r;
    logic [32:0] an;
    logic [32:0] am;
    an = n[32] ? 33'(-n) : 33'(n);
    am = m[32] ? 33'(-m) : 33'(m);
    r.an   = an[MAG_BITS-1:0];
    r.ad   = am[MAG_BITS-1:0];
    r.fix  = 1'b1;
    r.fone = 1'b0;
    if (m == 33'sd0) r.fone = !n[32];
    else if (n == 33'sd0) r.fone = 1'b0;
    else if (n[32] != m[32]) r.fone = 1'b0;
    else if (an >= am) r.fone = 1'b1;
    else r.fix = 1'b0;
    return r;
  endfunction

  function automatic logic signed [33:0] mul_t(input logic signed [32:0] d,
                                               input logic [16:0] l);
    logic signed [50:0] p;
    p = d * signed'({1'b0, l});
    return p[49:16];
  endfunction

  function automatic logic signed [36:0] mul_w(input logic signed [18:0] w,
                                               input logic signed [33:0] t);
    logic signed [52:0] p;
    p = w * t;
    return p[52:16];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [38:0] x);
    logic signed [38:0] r;
    if (x > SAT_HI) r = SAT_HI;
    else if (x < SAT_LO) r = SAT_LO;
    else r = x;
    return r[31:0];
  endfunction

  // configuration
  logic signed [17:0] kappa_r;
  logic        [16:0] eps_r;
  reg_idx_t           cidx;
  logic               cfg_wr;

  assign cidx       = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= KAPPA_RESET;
      eps_r   <= EPSILON_RESET;
    end else if (cfg_wr) begin
      unique case (cidx)
        REG_KAPPA:   kappa_r <= cfg_pwdata[17:0];
        REG_EPSILON: eps_r   <= cfg_pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (cidx)
      REG_KAPPA:   cfg_prdata = {{14{kappa_r[17]}}, kappa_r};
      REG_EPSILON: cfg_prdata = {15'd0, eps_r};
    endcase
  end

  // stage control
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;
  logic [NST-1:0] v_in;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  assign v_in        = {v_r[NST-2:0], in_ch.valid};
  assign in_ch.ready = adv[0];
  assign out_ch.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) if (adv[k]) v_r[k] <= v_in[k];
    end
  end

  // carried payload
  carry_t crr_r   [NST];
  carry_t crr_nxt [NST];
  lset_t  ls      [LANES];

  always_comb begin
    logic signed [31:0] qfl, ql, qr, qfr;
    qfl = sx(in_ch.q_far_left);
    ql  = sx(in_ch.q_left);
    qr  = sx(in_ch.q_right);
    qfr = sx(in_ch.q_far_right);
    crr_nxt[0].op   = in_ch.opcode;
    crr_nxt[0].ql   = ql;
    crr_nxt[0].qr   = qr;
    crr_nxt[0].d1   = 33'(ql) - 33'(qfl);
    crr_nxt[0].d2   = 33'(qr) - 33'(ql);
    crr_nxt[0].d3   = 33'(qfr) - 33'(qr);
    crr_nxt[0].fix  = '0;
    crr_nxt[0].fone = '0;
    ls[0] = lim_setup(crr_r[0].d2, crr_r[0].d1);
    ls[1] = lim_setup(crr_r[0].d1, crr_r[0].d2);
    ls[2] = lim_setup(crr_r[0].d3, crr_r[0].d2);
    ls[3] = lim_setup(crr_r[0].d2, crr_r[0].d3);
    crr_nxt[S_SET] = crr_r[0];
    for (int l = 0; l < LANES; l++) begin
      crr_nxt[S_SET].fix[l]  = ls[l].fix;
      crr_nxt[S_SET].fone[l] = ls[l].fone;
    end
    for (int k = S_SET + 1; k < NST; k++) crr_nxt[k] = crr_r[k-1];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) if (adv[k]) crr_r[k] <= crr_nxt[k];
  end

  // dividers
  logic [MAG_BITS-1:0] an_r [LANES];
  logic [MAG_BITS-1:0] ad_r [LANES];
  logic [DIV_BITS-1:0] q    [LANES];

  always_ff @(posedge clk) begin
    if (adv[S_SET]) begin
      for (int l = 0; l < LANES; l++) begin
        an_r[l] <= ls[l].an;
        ad_r[l] <= ls[l].ad;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_div
    mfr_div_pipe #(
      .STEPS (DIV_BITS),
      .W     (MAG_BITS)
    ) u_div (
      .clk   (clk),
      .en    (adv[S_DIV0 +: DIV_BITS]),
      .rem_i (an_r[l]),
      .ad_i  (ad_r[l]),
      .q_o   (q[l])
    );
  end

  // limited slopes, weights, blend
  logic signed [33:0] t_r [LANES];
  logic signed [36:0] p_r [LANES];
  logic signed [37:0] ul_r, ur_r;
  logic signed [37:0] bl_r, br_r;
  logic signed [31:0] left_r, right_r;
  logic [16:0]        limv [LANES];
  logic signed [18:0] kx, wm, wp;
  logic signed [55:0] el, er;
  logic signed [38:0] lsum, rsum;
  logic signed [32:0] qsum;
  carry_t             ct, co;

  always_comb begin
    ct = crr_r[S_TA-1];
    for (int l = 0; l < LANES; l++)
      limv[l] = ct.fix[l] ? (ct.fone[l] ? 17'(FIX_ONE) : 17'd0) : {1'b0, q[l]};
    kx = kappa_r;
    wm = 19'sd65536 - kx;
    wp = 19'sd65536 + kx;
    el = ul_r * signed'({1'b0, eps_r});
    er = ur_r * signed'({1'b0, eps_r});
    co   = crr_r[S_OUT-1];
    lsum = 39'(co.ql) + 39'(bl_r);
    rsum = 39'(co.qr) - 39'(br_r);
    qsum = 33'(co.ql) + 33'(co.qr);
  end

  always_ff @(posedge clk) begin
    if (adv[S_TA]) begin
      t_r[0] <= mul_t(ct.d1, limv[0]);
      t_r[1] <= mul_t(ct.d2, limv[1]);
      t_r[2] <= mul_t(ct.d2, limv[2]);
      t_r[3] <= mul_t(ct.d3, limv[3]);
    end
    if (adv[S_PW]) begin
      p_r[0] <= mul_w(wm, t_r[0]);
      p_r[1] <= mul_w(wp, t_r[1]);
      p_r[2] <= mul_w(wp, t_r[2]);
      p_r[3] <= mul_w(wm, t_r[3]);
    end
    if (adv[S_SUM]) begin
      ul_r <= 38'(p_r[0]) + 38'(p_r[1]);
      ur_r <= 38'(p_r[2]) + 38'(p_r[3]);
    end
    if (adv[S_EPS]) begin
      bl_r <= el[55:18];
      br_r <= er[55:18];
    end
    if (adv[S_OUT]) begin
      if (co.op) begin
        left_r  <= qsum[32:1];
        right_r <= qsum[32:1];
      end else begin
        left_r  <= sat(lsum);
        right_r <= sat(rsum);
      end
    end
  end

  assign out_ch.left_state  = left_r;
  assign out_ch.right_state = right_r;

endmodule
`default_nettype wire
